// ===== rtl/ip_range_table_search_unit_assert.svh =====
// assertion macros for the checker file
`ifndef IP_RANGE_TABLE_SEARCH_UNIT_ASSERT_SVH
`define IP_RANGE_TABLE_SEARCH_UNIT_ASSERT_SVH

// plain property, sampled on clk_i, off during reset
`define IRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication on the next cycle
`define IRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/irts_pkg.sv =====
package irts_pkg;

  localparam int IDX_W  = 12;
  localparam int IP_W   = 32;
  localparam int REC_W  = 24;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic REG_FIRST_ENTRY = 1'b0;
  localparam logic REG_LAST_ENTRY  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] first_entry;
    logic [IDX_W-1:0] last_entry;
  } irts_cfg_t;

endpackage

// ===== rtl/irts_ram.sv =====
module irts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/irts_apb_regs.sv =====
module irts_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irts_pkg::PADDR_W-1:0] paddr,
  input  logic [irts_pkg::DATA_W-1:0]  pwdata,
  output logic [irts_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output irts_pkg::irts_cfg_t          cfg_o
);

  import irts_pkg::*;

  irts_cfg_t        cfg_q;
  logic             wr_en;
  logic             reg_sel;
  logic [IDX_W-1:0] rd_val;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FIRST_ENTRY: cfg_q.first_entry <= pwdata[IDX_W-1:0];
        REG_LAST_ENTRY:  cfg_q.last_entry  <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_ENTRY: rd_val = cfg_q.first_entry;
      REG_LAST_ENTRY:  rd_val = cfg_q.last_entry;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

// ===== rtl/ip_range_table_search_unit.sv =====
// Range-start lookup over a table of TABLE_DEPTH entries, each a 32-bit start address and a
// 24-bit record offset. A write item (kind 0) stores one entry and gives no result; a lookup
// item (kind 1) halves between its low and high bounds (0 picks first_entry or last_entry) and
// returns the index of the last entry whose start does not exceed the address, or the low
// bound when none does, with that entry's record offset. The block takes one item at a time
// and is not ready until the item is finished and its result has been transferred. A write
// stores its entry in the table access state; each lookup halving step has a step state, a
// start-table read and a compare, and the search ends with the record read and the result.
// The pace is set by the one compare unit and the registered read of the start table in
// every step. When TABLE_DEPTH is below 4096 and not a power of two, each table access first
// folds the 12-bit index into the table by repeated compare and subtract.
module ip_range_table_search_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [irts_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [irts_pkg::IP_W-1:0]    entry_start_i,
  input  logic [irts_pkg::REC_W-1:0]   entry_record_i,
  input  logic [irts_pkg::IP_W-1:0]    ip_address_i,
  input  logic [irts_pkg::IDX_W-1:0]   range_low_i,
  input  logic [irts_pkg::IDX_W-1:0]   range_high_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [irts_pkg::IDX_W-1:0]   match_index_o,
  output logic [irts_pkg::REC_W-1:0]   record_offset_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irts_pkg::PADDR_W-1:0] paddr,
  input  logic [irts_pkg::DATA_W-1:0]  pwdata,
  output logic [irts_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  import irts_pkg::*;

  localparam int  AW        = $clog2(TABLE_DEPTH);
  localparam int  IDX_SPAN  = 1 << IDX_W;
  localparam bit  DEPTH_P2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int  RED_STEPS = (DEPTH_P2 || TABLE_DEPTH >= IDX_SPAN) ? 0 :
                              $clog2((IDX_SPAN + TABLE_DEPTH - 1) / TABLE_DEPTH);
  localparam int  CNT_W     = $clog2(RED_STEPS + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] PH_WR  = 2'd0;
  localparam logic [1:0] PH_CMP = 2'd1;
  localparam logic [1:0] PH_FIN = 2'd2;

  irts_cfg_t cfg;

  logic [2:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [IDX_W-1:0] left_q, left_d;
  logic [IDX_W:0]   right_q, right_d;
  logic [IDX_W-1:0] mid_q, mid_d;
  logic [IDX_W-1:0] red_q, red_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IP_W-1:0]  addr_q, addr_d;
  logic [IP_W-1:0]  wstart_q, wstart_d;
  logic [REC_W-1:0] wrec_q, wrec_d;

  logic             in_xfer;
  logic [IDX_W-1:0] lo, hi;
  logic [IDX_W:0]   span;
  logic [IDX_W:0]   mid_sum;
  logic [CNT_W-1:0] shamt;
  logic [IDX_W-1:0] fold_thr;
  logic [AW-1:0]    slot;
  logic             tbl_we, start_re, rec_re;
  logic [IP_W-1:0]  start_rdata;
  logic [REC_W-1:0] rec_rdata;
  logic [2:0]       mem_or_red;

  irts_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign lo = (range_low_i  == '0) ? cfg.first_entry : range_low_i;
  assign hi = (range_high_i == '0) ? cfg.last_entry  : range_high_i;

  assign span       = right_q - {1'b0, left_q};
  assign mid_sum    = {1'b0, left_q} + {1'b0, span[IDX_W:1]};
  assign shamt      = cnt_q - CNT_W'(1);
  assign fold_thr   = IDX_W'(TABLE_DEPTH) << shamt;
  assign slot       = AW'(red_q);
  assign mem_or_red = (RED_STEPS == 0) ? S_MEM : S_RED;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    left_d   = left_q;
    right_d  = right_q;
    mid_d    = mid_q;
    red_d    = red_q;
    cnt_d    = cnt_q;
    addr_d   = addr_q;
    wstart_d = wstart_q;
    wrec_d   = wrec_q;
    tbl_we   = 1'b0;
    start_re = 1'b0;
    rec_re   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (kind_i == KIND_WRITE) begin
            red_d    = entry_index_i;
            wstart_d = entry_start_i;
            wrec_d   = entry_record_i;
            phase_d  = PH_WR;
            cnt_d    = CNT_W'(RED_STEPS);
            state_d  = mem_or_red;
          end else begin
            left_d  = lo;
            right_d = (hi >= lo) ? ({1'b0, hi} + 1'b1) : {1'b0, lo};
            addr_d  = ip_address_i;
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        cnt_d   = CNT_W'(RED_STEPS);
        state_d = mem_or_red;
        if (span > 1) begin
          mid_d   = mid_sum[IDX_W-1:0];
          red_d   = mid_sum[IDX_W-1:0];
          phase_d = PH_CMP;
        end else begin
          red_d   = left_q;
          phase_d = PH_FIN;
        end
      end
      S_RED: begin
        // fold the index into the table, one compare and subtract per cycle
        if (red_q >= fold_thr) begin
          red_d = red_q - fold_thr;
        end
        cnt_d = shamt;
        if (cnt_q <= CNT_W'(1)) begin
          state_d = S_MEM;
        end
      end
      S_MEM: begin
        unique case (phase_q)
          PH_WR: begin
            tbl_we  = 1'b1;
            state_d = S_IDLE;
          end
          PH_CMP: begin
            start_re = 1'b1;
            state_d  = S_CMP;
          end
          default: begin
            rec_re  = 1'b1;
            state_d = S_OUT;
          end
        endcase
      end
      S_CMP: begin
        if (addr_q < start_rdata) begin
          right_d = {1'b0, mid_q};
        end else begin
          left_d = mid_q;
        end
        state_d = S_NEXT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_WR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    right_q  <= right_d;
    mid_q    <= mid_d;
    red_q    <= red_d;
    addr_q   <= addr_d;
    wstart_q <= wstart_d;
    wrec_q   <= wrec_d;
  end

  irts_ram #(
    .WIDTH (IP_W),
    .DEPTH (TABLE_DEPTH)
  ) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .re_i    (start_re),
    .addr_i  (slot),
    .wdata_i (wstart_q),
    .rdata_o (start_rdata)
  );

  irts_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .re_i    (rec_re),
    .addr_i  (slot),
    .wdata_i (wrec_q),
    .rdata_o (rec_rdata)
  );

  assign out_valid_o     = (state_q == S_OUT);
  assign match_index_o   = left_q;
  assign record_offset_o = rec_rdata;

endmodule

// ===== rtl/irts_checker.sv =====
`include "ip_range_table_search_unit_assert.svh"

module irts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [irts_pkg::IDX_W-1:0] match_index_o,
  input logic [irts_pkg::REC_W-1:0] record_offset_o
);

  // one item in flight: no new transfer while a result waits
  `IRTS_ASSERT(a_busy_with_result, !(out_valid_o && in_ready_o), "ready while result pending")

  `IRTS_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "ready after transfer")

  `IRTS_ASSERT_NEXT(a_single_result, out_valid_o && out_ready_i, !out_valid_o, "result repeated")

  `IRTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(match_index_o) && $stable(record_offset_o), "stalled result changed")

endmodule

bind ip_range_table_search_unit irts_checker u_irts_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

import irts_pkg::*;

localparam int TABLE_DEPTH = 4096;

typedef struct packed {
  logic             kind;
  logic [IDX_W-1:0] entry_index;
  logic [IP_W-1:0]  entry_start;
  logic [REC_W-1:0] entry_record;
  logic [IP_W-1:0]  ip_address;
  logic [IDX_W-1:0] range_low;
  logic [IDX_W-1:0] range_high;
} table_op_t;

typedef struct packed {
  logic [IDX_W-1:0] index;
  logic [REC_W-1:0] record;
} table_match_t;

typedef struct {
  int base;
  int len;
} span_t;

class match_scoreboard;
  logic [IP_W-1:0]  start_tbl [TABLE_DEPTH];
  logic [REC_W-1:0] record_tbl [TABLE_DEPTH];
  logic [IDX_W-1:0] first_idx;
  logic [IDX_W-1:0] last_idx;
  table_match_t     pending_matches [$];
  int               writes;
  int               lookups;
  int               errors;

  function new();
    first_idx = '0;
    last_idx  = '0;
    writes    = 0;
    lookups   = 0;
    errors    = 0;
  endfunction

  function void set_bound(logic sel, logic [IDX_W-1:0] value);
    if (sel == REG_FIRST_ENTRY) begin
      first_idx = value;
    end else begin
      last_idx = value;
    end
  endfunction

  // halving search: last entry in [lo, hi] whose start is not above the address
  function table_match_t locate_entry(table_op_t op);
    int unsigned  lo, hi, left, right, mid;
    table_match_t m;
    lo    = (op.range_low == '0) ? first_idx : op.range_low;
    hi    = (op.range_high == '0) ? last_idx : op.range_high;
    left  = lo;
    right = (hi >= lo) ? hi + 1 : lo;
    while (right - left > 1) begin
      mid = left + (right - left) / 2;
      if (op.ip_address < start_tbl[mid % TABLE_DEPTH]) begin
        right = mid;
      end else begin
        left = mid;
      end
    end
    m.index  = IDX_W'(left);
    m.record = record_tbl[left % TABLE_DEPTH];
    return m;
  endfunction

  function void note_item(table_op_t op);
    if (op.kind == KIND_WRITE) begin
      start_tbl[op.entry_index]  = op.entry_start;
      record_tbl[op.entry_index] = op.entry_record;
      writes++;
    end else begin
      pending_matches.push_back(locate_entry(op));
      lookups++;
    end
  endfunction

  function void check_result(logic [IDX_W-1:0] idx, logic [REC_W-1:0] rec);
    table_match_t want;
    if (pending_matches.size() == 0) begin
      $error("unexpected result: match_index %0d record_offset 0x%06h", idx, rec);
      errors++;
      return;
    end
    want = pending_matches.pop_front();
    if (idx !== want.index) begin
      $error("match_index: expected %0d, got %0d", want.index, idx);
      errors++;
    end
    if (rec !== want.record) begin
      $error("record_offset: expected 0x%06h, got 0x%06h", want.record, rec);
      errors++;
    end
  endfunction

  function int pending();
    return pending_matches.size();
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int ITEM_TARGET   = 1700;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 600;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               kind_i;
  logic [IDX_W-1:0]   entry_index_i;
  logic [IP_W-1:0]    entry_start_i;
  logic [REC_W-1:0]   entry_record_i;
  logic [IP_W-1:0]    ip_address_i;
  logic [IDX_W-1:0]   range_low_i;
  logic [IDX_W-1:0]   range_high_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [IDX_W-1:0]   match_index_o;
  logic [REC_W-1:0]   record_offset_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  match_scoreboard  sb;
  bit               written [TABLE_DEPTH];
  logic [IP_W-1:0]  shadow_start [TABLE_DEPTH];
  span_t            spans [$];
  logic [IDX_W-1:0] cfg_first;
  logic [IDX_W-1:0] cfg_last;
  int               items_sent;
  int               phases;
  bit               hold_req;
  bit               send_calm;
  bit               sink_calm;
  int unsigned      cycles;

  ip_range_table_search_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .entry_start_i  (entry_start_i),
    .entry_record_i (entry_record_i),
    .ip_address_i   (ip_address_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_index_o  (match_index_o),
    .record_offset_o(record_offset_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    table_op_t op;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        op.kind         = kind_i;
        op.entry_index  = entry_index_i;
        op.entry_start  = entry_start_i;
        op.entry_record = entry_record_i;
        op.ip_address   = ip_address_i;
        op.range_low    = range_low_i;
        op.range_high   = range_high_i;
        sb.note_item(op);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(match_index_o, record_offset_o);
      end
    end
  end

  function automatic int draw_wait(ref bit calm);
    if ($urandom_range(0, 24) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin : sink
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(input table_op_t op);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= op.kind;
    entry_index_i  <= op.entry_index;
    entry_start_i  <= op.entry_start;
    entry_record_i <= op.entry_record;
    ip_address_i   <= op.ip_address;
    range_low_i    <= op.range_low;
    range_high_i   <= op.range_high;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic do_write(input logic [IDX_W-1:0] idx, input logic [IP_W-1:0] start,
                          input logic [REC_W-1:0] rec);
    table_op_t op;
    op.kind         = KIND_WRITE;
    op.entry_index  = idx;
    op.entry_start  = start;
    op.entry_record = rec;
    op.ip_address   = $urandom();
    op.range_low    = IDX_W'($urandom());
    op.range_high   = IDX_W'($urandom());
    written[idx]      = 1'b1;
    shadow_start[idx] = start;
    send_item(op);
  endtask

  task automatic do_lookup(input logic [IP_W-1:0] ip, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi);
    table_op_t op;
    op.kind         = KIND_LOOKUP;
    op.entry_index  = IDX_W'($urandom());
    op.entry_start  = $urandom();
    op.entry_record = REC_W'($urandom());
    op.ip_address   = ip;
    op.range_low    = lo;
    op.range_high   = hi;
    send_item(op);
  endtask

  // true when every entry the search may touch has been written
  function automatic bit span_ok(logic [IDX_W-1:0] lo_f, logic [IDX_W-1:0] hi_f);
    int lo, hi;
    lo = (lo_f == '0) ? int'(cfg_first) : int'(lo_f);
    hi = (hi_f == '0) ? int'(cfg_last) : int'(hi_f);
    if (hi < lo) begin
      return written[lo];
    end
    for (int i = lo; i <= hi; i++) begin
      if (!written[i]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic random_lookup(input int w);
    span_t           sp;
    int              lo, hi, el, eh, pick, r;
    logic [IP_W-1:0] ip;
    repeat (20) begin
      sp = spans[(w >= 0) ? w : $urandom_range(0, spans.size() - 1)];
      lo = sp.base + $urandom_range(0, sp.len - 1);
      hi = lo + $urandom_range(0, sp.base + sp.len - 1 - lo);
      r  = $urandom_range(0, 9);
      if (r == 0 && lo > 1) begin
        hi = $urandom_range(1, lo - 1);
      end else if (r == 1) begin
        lo = 0;
      end else if (r == 2) begin
        hi = 0;
      end else if (r == 3) begin
        lo = 0;
        hi = 0;
      end
      if (span_ok(IDX_W'(lo), IDX_W'(hi))) begin
        el   = (lo == 0) ? int'(cfg_first) : lo;
        eh   = (hi == 0) ? int'(cfg_last) : hi;
        pick = (eh > el) ? $urandom_range(el, eh) : el;
        r    = $urandom_range(0, 9);
        if (r < 5) begin
          ip = shadow_start[pick] + IP_W'($urandom_range(0, 4)) - IP_W'(2);
        end else if (r == 5) begin
          ip = '0;
        end else if (r == 6) begin
          ip = '1;
        end else begin
          ip = $urandom();
        end
        do_lookup(ip, IDX_W'(lo), IDX_W'(hi));
        return;
      end
    end
  endtask

  // write a sorted run of entries, then search inside it
  task automatic fill_span();
    int                len, base, n;
    longint unsigned   acc;
    int unsigned       step_max;
    len      = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 300) : $urandom_range(2, 32);
    base     = $urandom_range(0, TABLE_DEPTH - len);
    step_max = 32'hFFFF_FFFF / len;
    acc      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1000);
    for (int i = 0; i < len; i++) begin
      do_write(IDX_W'(base + i), IP_W'(acc), REC_W'($urandom()));
      if ($urandom_range(0, 7) != 0) begin
        acc += $urandom_range(1, step_max);
      end
      if (acc > 64'hFFFF_FFFF) begin
        acc = 64'hFFFF_FFFF;
      end
    end
    spans.push_back(span_t'{base, len});
    n = $urandom_range(6, 20);
    repeat (n) random_lookup(spans.size() - 1);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic sel, input logic [IDX_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_FIRST_ENTRY) begin
      cfg_first = value;
    end else begin
      cfg_last = value;
    end
    sb.set_bound(sel, value);
    @(posedge clk_i);
  endtask

  task automatic next_phase();
    span_t sp;
    logic [IDX_W-1:0] f, l;
    drain_results();
    sp = spans[$urandom_range(0, spans.size() - 1)];
    case (phases)
      0: begin
        f = '0;
        l = '1;
      end
      1: begin
        f = '1;
        l = '0;
      end
      2: begin
        f = '1;
        l = '1;
      end
      3: begin
        f = '0;
        l = '0;
      end
      default: begin
        f = IDX_W'(sp.base);
        l = IDX_W'(sp.base + sp.len - 1);
      end
    endcase
    cfg_write(REG_FIRST_ENTRY, f);
    cfg_write(REG_LAST_ENTRY, l);
    phases++;
  endtask

  initial begin : stimulus
    int r, next_phase_at, holds;
    sb             = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_WRITE;
    entry_index_i  = '0;
    entry_start_i  = '0;
    entry_record_i = '0;
    ip_address_i   = '0;
    range_low_i    = '0;
    range_high_i   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_first      = '0;
    cfg_last       = '0;
    items_sent     = 0;
    phases         = 0;
    hold_req       = 1'b0;
    cycles         = 0;
    next_phase_at  = 0;
    holds          = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // low and high corners of the table, with duplicate and extreme starts
    do_write(12'd0, 32'h0000_0000, 24'h00_0000);
    do_write(12'd1, 32'h0000_0100, 24'hFF_FFFF);
    do_write(12'd2, 32'h0000_0100, 24'h12_3456);
    do_write(12'd3, 32'h8000_0000, 24'h00_00FF);
    do_write(12'd4, 32'hFFFF_FFFE, 24'h80_0000);
    do_write(12'd5, 32'hFFFF_FFFF, 24'hAB_CDEF);
    do_write(12'd4090, 32'h0000_00FF, 24'h00_0001);
    do_write(12'd4091, 32'h0000_0100, 24'h55_5555);
    do_write(12'd4092, 32'h7FFF_FFFF, 24'hAA_AAAA);
    do_write(12'd4093, 32'hFFFF_FF00, 24'h0F_0F0F);
    do_write(12'd4094, 32'hFFFF_FFFF, 24'hF0_F0F0);
    do_write(12'd4095, 32'hFFFF_FFFF, 24'hFF_FFFF);
    do_lookup(32'hFFFF_FFFF, 12'd1, 12'd5);
    do_lookup(32'h0000_0000, 12'd1, 12'd5);
    do_lookup(32'h0000_0100, 12'd1, 12'd5);
    do_lookup($urandom(), 12'd3, 12'd3);
    do_lookup($urandom(), 12'd5, 12'd2);
    do_lookup($urandom(), 12'd0, 12'd0);
    do_lookup(32'hFFFF_FFFF, 12'd4090, 12'd4095);
    do_lookup(32'h0000_0000, 12'd4090, 12'd4095);
    do_lookup($urandom(), 12'd4095, 12'd4094);
    do_lookup($urandom(), 12'd4094, 12'd0);
    spans.push_back(span_t'{0, 6});
    spans.push_back(span_t'{4090, 6});

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_phase_at) begin
        next_phase();
        next_phase_at = items_sent + PHASE_ITEMS;
      end
      if (holds < 2 && items_sent >= 500 + 700 * holds) begin
        hold_req = 1'b1;
        holds++;
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
        fill_span();
      end else if (r < 22) begin
        // stray write, often inside a sorted run so the order breaks
        if ($urandom_range(0, 1) == 0) begin
          do_write(IDX_W'($urandom()), $urandom(), REC_W'($urandom()));
        end else begin
          do_write(IDX_W'(spans[$urandom_range(0, spans.size() - 1)].base), $urandom(),
                   REC_W'($urandom()));
        end
      end else begin
        random_lookup(-1);
      end
    end

    drain_results();
    $display("covered %0d table writes and %0d lookups over %0d bound settings",
             sb.writes, sb.lookups, phases + 1);
    $display("runs filled: %0d, mismatches: %0d", spans.size(), sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
